@@ rtl/srr_pkg.sv @@
// ----------------------------------------------------------------------------
// srr_pkg: selective-repeat receiver shared types
// State encoding, controller/datapath command and status, result codes.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int PAYLOAD_BYTES = 20;
	localparam int HIGH_BYTES    = PAYLOAD_BYTES - 16;
	localparam int ENTRY_W       = 8 * PAYLOAD_BYTES;

	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_DLV = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_CHK,
		S_ACK,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic load;
		logic store;
		logic emit_ack;
		logic emit_dlv;
	} cmd_t;

	typedef struct packed {
		logic good;
		logic in_win;
		logic old;
		logic out_free;
		logic head_valid;
		logic next_valid;
	} sts_t;

endpackage

@@ rtl/srr_ctrl.sv @@
// ----------------------------------------------------------------------------
// srr_ctrl: selective-repeat receiver controller
// Sequences check, acknowledge and in-order drain for one packet at a time.
// ----------------------------------------------------------------------------
module srr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  srr_pkg::sts_t sts,
	output srr_pkg::cmd_t cmd
);

	srr_pkg::state_t state_q;
	srr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			srr_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = srr_pkg::S_SUM;
				end
			end
			srr_pkg::S_SUM: begin
				state_d = srr_pkg::S_CHK;
			end
			srr_pkg::S_CHK: begin
				if (sts.good && (sts.in_win || sts.old)) begin
					state_d = srr_pkg::S_ACK;
				end else begin
					state_d = srr_pkg::S_IDLE;
				end
			end
			srr_pkg::S_ACK: begin
				if (sts.out_free) begin
					state_d = sts.head_valid ? srr_pkg::S_DRAIN : srr_pkg::S_IDLE;
				end
			end
			srr_pkg::S_DRAIN: begin
				if (sts.out_free) begin
					state_d = sts.next_valid ? srr_pkg::S_DRAIN : srr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = srr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			srr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			srr_pkg::S_CHK: begin
				cmd.store = sts.good && sts.in_win;
			end
			srr_pkg::S_ACK: begin
				cmd.emit_ack = sts.out_free;
			end
			srr_pkg::S_DRAIN: begin
				cmd.emit_dlv = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/srr_dpath.sv @@
// ----------------------------------------------------------------------------
// srr_dpath: selective-repeat receiver datapath
// Packet capture, checksum, window slot memory and result register.
// ----------------------------------------------------------------------------
module srr_dpath #(
	parameter int WINDOW   = 16,
	parameter int SEQ_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  srr_pkg::cmd_t cmd,
	output srr_pkg::sts_t sts,
	input  logic [15:0]   seq_number,
	input  logic [31:0]   ack_number,
	input  logic [31:0]   check_value,
	input  logic [63:0]   data_word_low,
	input  logic [63:0]   data_word_mid,
	input  logic [31:0]   data_word_high,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          result_kind,
	output logic [15:0]   result_seq,
	output logic [15:0]   ack_check,
	output logic [63:0]   out_word_low,
	output logic [63:0]   out_word_mid,
	output logic [31:0]   out_word_high,
	output logic          last_of_run
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PW = IW + 1;
	localparam int DW = SEQ_BITS + 9;
	localparam logic SEQ_OK = ((64'(1) << SEQ_BITS) >= 64'(WINDOW));

	function automatic logic signed [10:0] byte_sum8(input logic [63:0] w);
		logic signed [10:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 11'(signed'(w[8*i +: 8]));
		end
		return s;
	endfunction

	// captured packet
	logic [SEQ_BITS-1:0]        seq_q;
	logic [31:0]                ack_q;
	logic [31:0]                chk_q;
	logic [srr_pkg::ENTRY_W-1:0] data_q;

	// checksum stage
	logic signed [12:0]  psum_s1;
	logic [31:0]         sa_s1;
	logic [SEQ_BITS-1:0] dist_s1;

	// window state
	logic [SEQ_BITS-1:0]         exp_q;
	logic [IW-1:0]               head_q;
	logic [WINDOW-1:0]           valid_q;
	logic [srr_pkg::ENTRY_W-1:0] mem [WINDOW];
	logic [srr_pkg::ENTRY_W-1:0] rd_q;

	logic [31:0]   seq_in32;
	logic [31:0]   seq32;
	logic [31:0]   seq_inc32;
	logic [31:0]   exp32;
	logic [31:0]   total;
	logic [DW-1:0] dist_x;
	logic [PW-1:0] phys_sum;
	logic [IW-1:0] phys;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] rd_addr;

	assign seq_in32  = 32'(seq_number);
	assign seq32     = 32'(seq_q);
	assign seq_inc32 = 32'(seq_q + SEQ_BITS'(1));
	assign exp32     = 32'(exp_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q  <= seq_in32[SEQ_BITS-1:0];
			ack_q  <= ack_number;
			chk_q  <= check_value;
			data_q <= {data_word_high, data_word_mid, data_word_low};
		end
		psum_s1 <= 13'(byte_sum8(data_q[63:0])) + 13'(byte_sum8(data_q[127:64]))
			+ 13'(byte_sum8({32'b0, data_q[159:128]}));
		sa_s1   <= seq32 + ack_q;
		dist_s1 <= seq_q - exp_q;
	end

	assign total    = sa_s1 + 32'(psum_s1);
	assign dist_x   = DW'(dist_s1);
	assign phys_sum = PW'(head_q) + PW'(dist_x[IW-1:0]);
	assign phys     = (phys_sum >= PW'(WINDOW)) ? IW'(phys_sum - PW'(WINDOW))
	                                            : phys_sum[IW-1:0];
	assign head_inc = (head_q == IW'(WINDOW - 1)) ? '0 : head_q + IW'(1);
	assign rd_addr  = cmd.emit_dlv ? head_inc : head_q;

	assign sts.good       = (total == chk_q);
	assign sts.in_win     = (dist_x < DW'(WINDOW));
	assign sts.old        = SEQ_OK && ((dist_x + DW'(WINDOW)) >= (DW'(1) << SEQ_BITS));
	assign sts.out_free   = !out_valid || out_ready;
	assign sts.head_valid = valid_q[head_q];
	assign sts.next_valid = valid_q[head_inc] && (head_inc != head_q);

	// slot memory; duplicates keep the held copy
	always_ff @(posedge clk) begin
		if (cmd.store && !valid_q[phys]) begin
			mem[phys] <= data_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			exp_q   <= '0;
			head_q  <= '0;
		end else begin
			if (cmd.store) begin
				valid_q[phys] <= 1'b1;
			end
			if (cmd.emit_dlv) begin
				valid_q[head_q] <= 1'b0;
				exp_q           <= exp_q + SEQ_BITS'(1);
				head_q          <= head_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_ack || cmd.emit_dlv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ack) begin
			result_kind   <= srr_pkg::KIND_ACK;
			result_seq    <= seq32[15:0];
			ack_check     <= seq_inc32[15:0];
			out_word_low  <= '0;
			out_word_mid  <= '0;
			out_word_high <= '0;
			last_of_run   <= !valid_q[head_q];
		end else if (cmd.emit_dlv) begin
			result_kind   <= srr_pkg::KIND_DLV;
			result_seq    <= exp32[15:0];
			ack_check     <= '0;
			out_word_low  <= rd_q[63:0];
			out_word_mid  <= rd_q[127:64];
			out_word_high <= rd_q[159:128];
			last_of_run   <= !sts.next_valid;
		end
	end

endmodule

@@ rtl/selective_repeat_receiver.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_receiver: selective-repeat ARQ receive window
// Checks each packet, acknowledges it, buffers it and delivers in order.
// ----------------------------------------------------------------------------
// The ack beat is registered from the ack state, after the sum and check states,
// and waits in the ack state while the output is held. A new packet is taken
// only after the last one is done; a good packet's deliveries follow its ack (one
// per cycle while the output is taken), and a dropped packet ends after check.
// Reset: asynchronous; clears the window valid bits, expected number and
// output valid at once. Slot memory is not cleared.
module selective_repeat_receiver #(
	parameter int WINDOW   = 16,
	parameter int SEQ_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] seq_number,
	input  logic [31:0] ack_number,
	input  logic [31:0] check_value,
	input  logic [63:0] data_word_low,
	input  logic [63:0] data_word_mid,
	input  logic [31:0] data_word_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [15:0] result_seq,
	output logic [15:0] ack_check,
	output logic [63:0] out_word_low,
	output logic [63:0] out_word_mid,
	output logic [31:0] out_word_high,
	output logic        last_of_run
);

	srr_pkg::cmd_t cmd;
	srr_pkg::sts_t sts;

	srr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srr_dpath #(
		.WINDOW   (WINDOW),
		.SEQ_BITS (SEQ_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.seq_number     (seq_number),
		.ack_number     (ack_number),
		.check_value    (check_value),
		.data_word_low  (data_word_low),
		.data_word_mid  (data_word_mid),
		.data_word_high (data_word_high),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.result_seq     (result_seq),
		.ack_check      (ack_check),
		.out_word_low   (out_word_low),
		.out_word_mid   (out_word_mid),
		.out_word_high  (out_word_high),
		.last_of_run    (last_of_run)
	);

	a_one_packet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a packet is in progress");

	a_ack_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == srr_pkg::KIND_ACK) |->
		(out_word_low == '0) && (out_word_mid == '0) && (out_word_high == '0))
		else $error("ack beat carries payload");

	a_dlv_check: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == srr_pkg::KIND_DLV) |-> (ack_check == '0))
		else $error("delivery beat carries ack check");

	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_ack && cmd.emit_dlv) && !(cmd.store && cmd.emit_dlv))
		else $error("conflicting datapath commands");

endmodule
